// File: rtl/core/bam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bam_pkg
// Shared codes and default sizes for the banked address mapper.
// ----------------------------------------------------------------------------
package bam_pkg;

    // Bus commands carried by each input word.
    localparam logic [2:0] CMD_CPU_RD = 3'd0;
    localparam logic [2:0] CMD_CPU_WR = 3'd1;
    localparam logic [2:0] CMD_PPU_RD = 3'd2;
    localparam logic [2:0] CMD_PPU_WR = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;
    localparam logic [2:0] CMD_ACK    = 3'd5;

    // Result targets.
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_WRAM = 2'd1;
    localparam logic [1:0] TGT_PRG  = 2'd2;
    localparam logic [1:0] TGT_PAT  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_PRG_UNITS = 1'b0;
    localparam logic CFG_PAT_UNITS = 1'b1;

    // Configuration reset values.
    localparam logic [7:0] PRG_UNITS_RESET = 8'd2;
    localparam logic [7:0] PAT_UNITS_RESET = 8'd0;

    // Mapper register groups, chosen by CPU address bits 14:13.
    localparam logic [1:0] GRP_SELECT = 2'd0;
    localparam logic [1:0] GRP_MIRROR = 2'd1;
    localparam logic [1:0] GRP_LATCH  = 2'd2;
    localparam logic [1:0] GRP_ENABLE = 2'd3;

    // Work RAM size.
    localparam int WORK_RAM_BYTES_DEF = 8192;

endpackage : bam_pkg
`default_nettype wire

// File: rtl/core/banked_address_mapper_scanline_irq_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// banked_address_mapper_scanline_irq_top
// Cartridge bank mapper with 8 KB work RAM and a scanline interrupt counter.
// ----------------------------------------------------------------------------
// Usage:
// Each input word (command, address, write_data) is taken at a rising edge
// with in_valid high and in_stall low. Every word gives exactly one result
// word on the output channel (claimed, target, memory_address, read_byte,
// pattern_write, irq_line, mirroring), taken when out_valid is high and
// out_stall is low. The configuration port (cfg_we, cfg_index, cfg_data)
// sets the program and pattern ROM unit counts. The user must write it only
// while the block is idle; the block does not enforce this. A word passes
// through WORK and FIN into the output register, and a wrapped ROM/pattern
// read also through DIV, where the bank remainder is worked out one bit per
// cycle in a shared divider. A new word is taken only while idle or as the
// previous result is loaded into the output register. The work RAM is a
// single-port synchronous memory; a word reads or writes it in the cycle
// it is accepted. After reset the block clears the work RAM, one byte per
// cycle, over all WORK_RAM_BYTES (8192) bytes, holding in_stall high.
// A stalled result is held in the output register; the next word may still
// be accepted and worked on, and it waits until the output register frees.
// ----------------------------------------------------------------------------
module banked_address_mapper_scanline_irq_top
    import bam_pkg::*;
#(
    parameter int WORK_RAM_BYTES = WORK_RAM_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  command,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             claimed,
    output logic [1:0]       target,
    output logic [20:0]      memory_address,
    output logic [7:0]       read_byte,
    output logic             pattern_write,
    output logic             irq_line,
    output logic             mirroring
);

    localparam int RAM_AW = $clog2(WORK_RAM_BYTES);
    localparam logic [RAM_AW-1:0] RAM_LAST = RAM_AW'(WORK_RAM_BYTES - 1);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WORK  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [RAM_AW-1:0] clr_addr_reg;

    // Configuration registers.
    logic [7:0] prg_units_reg;
    logic [7:0] pat_units_reg;

    // Mapper state.
    logic [2:0] select_reg;
    logic       prg_swap_reg;
    logic       chr_swap_reg;
    logic [7:0] bank_reg [8];
    logic       hmirror_reg;
    logic [7:0] irq_count_reg;
    logic [7:0] irq_reload_reg;
    logic       irq_enable_reg;
    logic       irq_flag_reg;
    logic       reload_pend_reg;

    // Item held between stages.
    logic [2:0]  cmd_reg;
    logic [15:0] addr_reg;

    // Result fields being built.
    logic       res_claimed_reg;
    logic [1:0] res_target_reg;
    logic       res_pwrite_reg;
    logic [7:0] res_bank_reg;

    // Shared remainder unit.
    logic [10:0] divisor_reg;
    logic [10:0] rem_reg;
    logic [7:0]  div_bits_reg;
    logic [2:0]  div_step_reg;

    // Work RAM.
    logic [7:0] wram_mem [WORK_RAM_BYTES];
    logic [7:0] wram_rdata_reg;

    // Output register.
    logic        out_valid_reg;
    logic        out_claimed_reg;
    logic [1:0]  out_target_reg;
    logic [20:0] out_maddr_reg;
    logic [7:0]  out_rbyte_reg;
    logic        out_pwrite_reg;
    logic        out_irq_reg;
    logic        out_mirror_reg;

    // Handshake decode.
    logic out_free;
    logic in_accept;
    logic fin_load;
    logic mod_needed;

    assign out_free  = !out_valid_reg || !out_stall;
    assign fin_load  = (state_reg == S_FIN) && out_free;
    assign in_stall  = !((state_reg == S_IDLE) || fin_load);
    assign in_accept = in_valid && !in_stall;

    // Decode of the accepted word.
    logic in_cpu_wr;
    logic in_wram_hit;
    logic in_reg_wr;
    logic [1:0] in_group;

    assign in_cpu_wr   = (command == CMD_CPU_WR);
    assign in_wram_hit = (address[15:13] == 3'b011);
    assign in_reg_wr   = in_accept && in_cpu_wr && address[15];
    assign in_group    = address[14:13];

    // Scanline counter step.
    logic [7:0] tick_count;
    logic       tick_reload;

    always_comb
    begin
        tick_reload = reload_pend_reg || (irq_count_reg == 8'd0);
        if (tick_reload)
        begin
            tick_count = irq_reload_reg;
        end
        else
        begin
            tick_count = irq_count_reg - 8'd1;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == RAM_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                state_next = mod_needed ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                if (div_step_reg == 3'd7)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_load)
                begin
                    state_next = in_accept ? S_WORK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_units_reg <= PRG_UNITS_RESET;
            pat_units_reg <= PAT_UNITS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_PRG_UNITS)
            begin
                prg_units_reg <= cfg_data;
            end
            else
            begin
                pat_units_reg <= cfg_data;
            end
        end
    end

    // Mapper registers and interrupt counter, updated as a word is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg      <= 3'd0;
            prg_swap_reg    <= 1'b0;
            chr_swap_reg    <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                bank_reg[i] <= 8'd0;
            end
            hmirror_reg     <= 1'b1;
            irq_count_reg   <= 8'd0;
            irq_reload_reg  <= 8'd0;
            irq_enable_reg  <= 1'b0;
            irq_flag_reg    <= 1'b0;
            reload_pend_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            if (in_reg_wr)
            begin
                case (in_group)
                    GRP_SELECT:
                    begin
                        if (address[0])
                        begin
                            bank_reg[select_reg] <= write_data;
                        end
                        else
                        begin
                            select_reg   <= write_data[2:0];
                            prg_swap_reg <= write_data[6];
                            chr_swap_reg <= write_data[7];
                        end
                    end
                    GRP_MIRROR:
                    begin
                        // Odd addresses are the RAM protect register, ignored.
                        if (!address[0])
                        begin
                            hmirror_reg <= write_data[0];
                        end
                    end
                    GRP_LATCH:
                    begin
                        if (address[0])
                        begin
                            reload_pend_reg <= 1'b1;
                        end
                        else
                        begin
                            irq_reload_reg <= write_data;
                        end
                    end
                    GRP_ENABLE:
                    begin
                        if (address[0])
                        begin
                            irq_enable_reg <= 1'b1;
                        end
                        else
                        begin
                            irq_enable_reg <= 1'b0;
                            irq_flag_reg   <= 1'b0;
                        end
                    end
                    default:
                    begin
                        select_reg <= select_reg;
                    end
                endcase
            end
            else if (command == CMD_TICK)
            begin
                irq_count_reg <= tick_count;
                if (tick_reload)
                begin
                    reload_pend_reg <= 1'b0;
                end
                if ((tick_count == 8'd0) && irq_enable_reg)
                begin
                    irq_flag_reg <= 1'b1;
                end
            end
            else if (command == CMD_ACK)
            begin
                irq_flag_reg <= 1'b0;
            end
        end
    end

    // Work RAM: clearing pass after reset, then one access per accepted word.
    logic              wram_we;
    logic              wram_re;
    logic [RAM_AW-1:0] wram_addr;
    logic [7:0]        wram_wdata;

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wram_we    = 1'b1;
            wram_re    = 1'b0;
            wram_addr  = clr_addr_reg;
            wram_wdata = 8'd0;
        end
        else
        begin
            wram_we    = in_accept && in_cpu_wr && in_wram_hit;
            wram_re    = in_accept && (command == CMD_CPU_RD) && in_wram_hit;
            wram_addr  = address[RAM_AW-1:0];
            wram_wdata = write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wram_we)
        begin
            wram_mem[wram_addr] <= wram_wdata;
        end
        if (wram_re)
        begin
            wram_rdata_reg <= wram_mem[wram_addr];
        end
    end

    // Window bank lookup for the held item.
    logic       w_cpu;
    logic       w_ppu;
    logic       w_chr_hit;
    logic       map_prg;
    logic       map_chr;
    logic [7:0] prg_second_last;
    logic [7:0] prg_last;
    logic [7:0] prg_win_bank;
    logic [7:0] pat_win_bank;
    logic [7:0] chr_pair;
    logic [2:0] chr_slot;
    logic [2:0] chr_single_idx;

    always_comb
    begin
        w_cpu     = (cmd_reg == CMD_CPU_RD) || (cmd_reg == CMD_CPU_WR);
        w_ppu     = (cmd_reg == CMD_PPU_RD) || (cmd_reg == CMD_PPU_WR);
        w_chr_hit = (addr_reg[15:13] == 3'b000);
        map_prg   = (cmd_reg == CMD_CPU_RD) && addr_reg[15];
        map_chr   = w_ppu && w_chr_hit
                    && ((cmd_reg == CMD_PPU_RD) || (pat_units_reg == 8'd0));

        // Fixed program banks, kept to 8 bits.
        prg_second_last = {prg_units_reg[6:0], 1'b0} - 8'd2;
        prg_last        = {prg_units_reg[6:0], 1'b0} - 8'd1;
        case (addr_reg[14:13])
            2'd0:    prg_win_bank = prg_swap_reg ? prg_second_last : bank_reg[6];
            2'd1:    prg_win_bank = bank_reg[7];
            2'd2:    prg_win_bank = prg_swap_reg ? bank_reg[6] : prg_second_last;
            default: prg_win_bank = prg_last;
        endcase

        // Pattern banks: two 2 KB pairs and four 1 KB singles.
        chr_slot       = addr_reg[12:10] ^ {chr_swap_reg, 2'b00};
        chr_pair       = bank_reg[{2'b00, chr_slot[1]}];
        chr_single_idx = chr_slot - 3'd2;
        if (!chr_slot[2])
        begin
            pat_win_bank = chr_slot[0] ? (chr_pair | 8'h01) : (chr_pair & 8'hFE);
        end
        else
        begin
            pat_win_bank = bank_reg[chr_single_idx];
        end

        mod_needed = (map_prg && (prg_units_reg != 8'd0))
                     || (map_chr && (pat_units_reg != 8'd0));
    end

    // Remainder step: one dividend bit per cycle.
    logic [11:0] div_trial;
    logic [11:0] div_diff;
    logic [10:0] rem_step;

    always_comb
    begin
        div_trial = {rem_reg, div_bits_reg[7]};
        div_diff  = div_trial - {1'b0, divisor_reg};
        if (div_trial >= {1'b0, divisor_reg})
        begin
            rem_step = div_diff[10:0];
        end
        else
        begin
            rem_step = div_trial[10:0];
        end
    end

    // Item registers, result building and the remainder unit.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg  <= command;
            addr_reg <= address;
        end
        if (state_reg == S_WORK)
        begin
            res_claimed_reg <= (w_cpu && (addr_reg[15] || (addr_reg[15:13] == 3'b011)))
                               || map_chr;
            if (w_cpu && (addr_reg[15:13] == 3'b011))
            begin
                res_target_reg <= TGT_WRAM;
            end
            else if (map_prg)
            begin
                res_target_reg <= TGT_PRG;
            end
            else if (map_chr)
            begin
                res_target_reg <= TGT_PAT;
            end
            else
            begin
                res_target_reg <= TGT_NONE;
            end
            res_pwrite_reg <= map_chr && (cmd_reg == CMD_PPU_WR);
            res_bank_reg   <= map_prg ? prg_win_bank : pat_win_bank;
            div_bits_reg   <= map_prg ? prg_win_bank : pat_win_bank;
            divisor_reg    <= map_prg ? {2'b00, prg_units_reg, 1'b0}
                                      : {pat_units_reg, 3'b000};
            rem_reg        <= 11'd0;
        end
        if (state_reg == S_DIV)
        begin
            rem_reg      <= rem_step;
            div_bits_reg <= {div_bits_reg[6:0], 1'b0};
            if (div_step_reg == 3'd7)
            begin
                res_bank_reg <= rem_step[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_step_reg <= 3'd0;
        end
        else if (state_reg == S_DIV)
        begin
            div_step_reg <= div_step_reg + 3'd1;
        end
        else
        begin
            div_step_reg <= 3'd0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            out_claimed_reg <= res_claimed_reg;
            out_target_reg  <= res_target_reg;
            out_pwrite_reg  <= res_pwrite_reg;
            out_irq_reg     <= irq_flag_reg;
            out_mirror_reg  <= hmirror_reg;
            case (res_target_reg)
                TGT_PRG: out_maddr_reg <= {res_bank_reg, addr_reg[12:0]};
                TGT_PAT: out_maddr_reg <= {3'b000, res_bank_reg, addr_reg[9:0]};
                default: out_maddr_reg <= 21'd0;
            endcase
            if ((res_target_reg == TGT_WRAM) && (cmd_reg == CMD_CPU_RD))
            begin
                out_rbyte_reg <= wram_rdata_reg;
            end
            else
            begin
                out_rbyte_reg <= 8'd0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign claimed        = out_claimed_reg;
    assign target         = out_target_reg;
    assign memory_address = out_maddr_reg;
    assign read_byte      = out_rbyte_reg;
    assign pattern_write  = out_pwrite_reg;
    assign irq_line       = out_irq_reg;
    assign mirroring      = out_mirror_reg;

    // Checks on the sequencer and the result fields.
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("input word taken during work RAM clearing");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (divisor_reg != 11'd0))
        else $error("remainder unit started with a zero divisor");

    a_pwrite_target: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pattern_write) |-> (claimed && (target == TGT_PAT)))
        else $error("pattern write strobe without a pattern memory claim");

    a_maddr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((target == TGT_NONE) || (target == TGT_WRAM)))
        |-> (memory_address == 21'd0))
        else $error("mapped address given for a non-ROM target");

    a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (command == CMD_ACK)) |=> !irq_flag_reg)
        else $error("interrupt flag survived an acknowledge");

endmodule : banked_address_mapper_scanline_irq_top
`default_nettype wire
